>>> hdl/epdd_pkg.sv
// Shared constants, types and the digit pattern table for the echo rangefinder display.
`timescale 1ns / 1ps
`default_nettype none
package epdd_pkg;

  localparam int COUNT_BITS = 8;
  localparam int DIGITS = 4;
  localparam int REG_BITS = 10;
  localparam int FRAC_BITS = 8;
  localparam int PROD_BITS = COUNT_BITS + REG_BITS;
  localparam int LIMIT_BITS = REG_BITS + FRAC_BITS;
  localparam int CMP_BITS = (PROD_BITS > LIMIT_BITS) ? PROD_BITS : LIMIT_BITS;
  localparam int SEG_BITS = 7;
  localparam int EN_BITS = 4;
  localparam int CFG_INDEX_BITS = 2;
  localparam int QDEPTH = 4;
  localparam int QPTR_BITS = $clog2(QDEPTH);
  localparam int QCNT_BITS = $clog2(QDEPTH + 1);
  localparam int DIGIT_IDX_BITS = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam int BCD_BITS = 4;
  localparam int DIV10_MUL = 205;
  localparam int DIV10_SHIFT = 11;
  localparam int DIV_PROD_BITS = REG_BITS + 8;

  localparam logic [REG_BITS-1:0] SCALE_RESET = REG_BITS'(281);
  localparam logic [REG_BITS-1:0] MIN_RESET = REG_BITS'(5);
  localparam logic [REG_BITS-1:0] MAX_RESET = REG_BITS'(200);

  localparam logic [CFG_INDEX_BITS-1:0] REG_SCALE = CFG_INDEX_BITS'(0);
  localparam logic [CFG_INDEX_BITS-1:0] REG_MIN = CFG_INDEX_BITS'(1);
  localparam logic [CFG_INDEX_BITS-1:0] REG_MAX = CFG_INDEX_BITS'(2);

  typedef struct packed {
    logic [REG_BITS-1:0] scale_factor_q8;
    logic [REG_BITS-1:0] min_distance;
    logic [REG_BITS-1:0] max_distance;
  } cfg_regs_t;

  typedef struct packed {
    logic                 not_empty;
    logic [QCNT_BITS-1:0] free;
  } queue_status_t;

  function automatic logic [SEG_BITS-1:0] seg_pattern(input logic [BCD_BITS-1:0] digit);
    logic [SEG_BITS-1:0] pattern;
    case (digit)
      4'd0: pattern = 7'h3F;
      4'd1: pattern = 7'h06;
      4'd2: pattern = 7'h5B;
      4'd3: pattern = 7'h4F;
      4'd4: pattern = 7'h66;
      4'd5: pattern = 7'h6D;
      4'd6: pattern = 7'h7D;
      4'd7: pattern = 7'h07;
      4'd8: pattern = 7'h7F;
      4'd9: pattern = 7'h67;
      default: pattern = 7'h00;
    endcase
    return pattern;
  endfunction

endpackage
`default_nettype wire

>>> hdl/epdd_front.sv
// Front part: edge detection, pulse width, scaling and range test.
`timescale 1ns / 1ps
`default_nettype none
module epdd_front
  import epdd_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic                echo_level,
  input  wire cfg_regs_t           cfg,
  input  wire queue_status_t       q_status,
  output logic                     push,
  output logic [REG_BITS-1:0]      push_whole
);

  logic [COUNT_BITS-1:0] tick_count;
  logic                  echo_previous;
  logic [COUNT_BITS-1:0] start_count;
  logic                  measuring;
  logic                  pulse_valid;
  logic [COUNT_BITS-1:0] pulse;
  logic                  prod_valid;
  logic [PROD_BITS-1:0]  prod;

  logic                  accept;
  logic                  rise;
  logic                  fall;
  logic [1:0]            inflight;
  logic [CMP_BITS-1:0]   prod_ext;
  logic [CMP_BITS-1:0]   lo_limit;
  logic [CMP_BITS-1:0]   hi_limit;

  assign inflight = {1'b0, pulse_valid} + {1'b0, prod_valid};
  assign in_ready = QCNT_BITS'(inflight) < q_status.free;
  assign accept = in_valid && in_ready;
  assign rise = echo_level && !echo_previous;
  assign fall = !echo_level && echo_previous && measuring;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count <= '0;
      echo_previous <= 1'b0;
      start_count <= '0;
      measuring <= 1'b0;
      pulse_valid <= 1'b0;
      prod_valid <= 1'b0;
    end else begin
      pulse_valid <= 1'b0;
      prod_valid <= pulse_valid;
      if (accept) begin
        echo_previous <= echo_level;
        tick_count <= tick_count + COUNT_BITS'(1);
        if (rise) begin
          start_count <= tick_count;
          measuring <= 1'b1;
        end else if (fall) begin
          measuring <= 1'b0;
          pulse_valid <= tick_count > start_count;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pulse <= tick_count - start_count;
    end
    prod <= PROD_BITS'(pulse) * PROD_BITS'(cfg.scale_factor_q8);
  end

  assign prod_ext = CMP_BITS'(prod);
  assign lo_limit = CMP_BITS'({cfg.min_distance, FRAC_BITS'(0)});
  assign hi_limit = CMP_BITS'({cfg.max_distance, FRAC_BITS'(0)});
  assign push = prod_valid && (prod_ext > lo_limit) && (prod_ext < hi_limit);
  assign push_whole = REG_BITS'(prod >> FRAC_BITS);

endmodule
`default_nettype wire

>>> hdl/epdd_queue.sv
// Short queue of accepted distances between the front and back parts.
`timescale 1ns / 1ps
`default_nettype none
module epdd_queue
  import epdd_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire logic [REG_BITS-1:0] wdata,
  input  wire logic                pop,
  output logic [REG_BITS-1:0]      rdata,
  output queue_status_t            status
);

  logic [REG_BITS-1:0]  entries [QDEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QCNT_BITS-1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_BITS'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_BITS'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wdata;
    end
  end

  assign rdata = entries[rd_ptr];
  assign status.not_empty = count != '0;
  assign status.free = QCNT_BITS'(QDEPTH) - count;

endmodule
`default_nettype wire

>>> hdl/epdd_back.sv
// Back part: decimal digit sequencer and the registered result stage.
`timescale 1ns / 1ps
`default_nettype none
module epdd_back
  import epdd_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire queue_status_t       q_status,
  input  wire logic [REG_BITS-1:0] q_rdata,
  output logic                     pop,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [SEG_BITS-1:0]      segments,
  output logic [EN_BITS-1:0]       digit_enable_n,
  output logic [REG_BITS-1:0]      distance_whole,
  output logic                     last_digit
);

  logic                      active;
  logic [DIGIT_IDX_BITS-1:0] digit_idx;
  logic [REG_BITS-1:0]       rest;
  logic [REG_BITS-1:0]       whole;

  logic                      advance;
  logic                      is_last;
  logic [DIV_PROD_BITS-1:0]  div_prod;
  logic [REG_BITS-1:0]       quotient;
  logic [BCD_BITS-1:0]       remainder;
  logic [EN_BITS-1:0]        enable_n;

  assign advance = active && (!out_valid || out_ready);
  assign is_last = digit_idx == DIGIT_IDX_BITS'(DIGITS - 1);
  assign pop = q_status.not_empty && (!active || (advance && is_last));

  assign div_prod = DIV_PROD_BITS'(rest) * DIV_PROD_BITS'(DIV10_MUL);
  assign quotient = REG_BITS'(div_prod >> DIV10_SHIFT);
  assign remainder = BCD_BITS'(rest - REG_BITS'(quotient * REG_BITS'(10)));

  always_comb begin
    if (int'(digit_idx) < EN_BITS) begin
      enable_n = ~(EN_BITS'(1) << digit_idx);
    end else begin
      enable_n = '1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        active <= 1'b1;
      end else if (advance && is_last) begin
        active <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      digit_idx <= '0;
      rest <= q_rdata;
      whole <= q_rdata;
    end else if (advance) begin
      digit_idx <= digit_idx + DIGIT_IDX_BITS'(1);
      rest <= quotient;
    end
    if (advance) begin
      segments <= seg_pattern(remainder);
      digit_enable_n <= enable_n;
      distance_whole <= whole;
      last_digit <= is_last;
    end
  end

endmodule
`default_nettype wire

>>> hdl/echo_pulse_distance_display.sv
// Top level of the echo pulse rangefinder with seven-segment digit output.
// Throughput: one tick request per cycle while the queue has room; each pulse passing
// the range test yields four digit results, one per cycle while out_ready is high, set
// by the single digit sequencer in the back part. A four-entry distance queue absorbs
// bursts; ticks stall only while it could overflow. Reset is synchronous and clears the
// counters, edge state and queue and loads the default configuration.
`timescale 1ns / 1ps
`default_nettype none
module echo_pulse_distance_display
  import epdd_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic                      echo_level,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [SEG_BITS-1:0]            segments,
  output logic [EN_BITS-1:0]             digit_enable_n,
  output logic [REG_BITS-1:0]            distance_whole,
  output logic                           last_digit,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [REG_BITS-1:0]       cfg_data
);

  cfg_regs_t           cfg;
  queue_status_t       q_status;
  logic                push;
  logic [REG_BITS-1:0] push_whole;
  logic                pop;
  logic [REG_BITS-1:0] q_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.scale_factor_q8 <= SCALE_RESET;
      cfg.min_distance <= MIN_RESET;
      cfg.max_distance <= MAX_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SCALE: cfg.scale_factor_q8 <= cfg_data;
        REG_MIN:   cfg.min_distance <= cfg_data;
        REG_MAX:   cfg.max_distance <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  epdd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .echo_level (echo_level),
    .cfg        (cfg),
    .q_status   (q_status),
    .push       (push),
    .push_whole (push_whole)
  );

  epdd_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wdata  (push_whole),
    .pop    (pop),
    .rdata  (q_rdata),
    .status (q_status)
  );

  epdd_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_status       (q_status),
    .q_rdata        (q_rdata),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .segments       (segments),
    .digit_enable_n (digit_enable_n),
    .distance_whole (distance_whole),
    .last_digit     (last_digit)
  );

endmodule
`default_nettype wire
